@@ rtl/harris_laser_amplitude_macros.svh @@
// Assertion macros for the Harris laser amplitude pipeline.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef HARRIS_LASER_AMPLITUDE_MACROS_SVH
`define HARRIS_LASER_AMPLITUDE_MACROS_SVH
`define HLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define HLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/hla_pkg.sv @@
// Shared types, constants and helpers for the Harris laser amplitude pipeline.
// No dependencies.
`default_nettype none
package hla_pkg;
  localparam int COORD_BITS = 32;
  localparam int PHASE_BITS_DEF = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W = 35;
  localparam int COS_TERMS = 8;
  localparam int EXP_TERMS = 12;
  localparam int COS_LAT = 3 + 2 * COS_TERMS;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  localparam int unsigned COS_DIV_C [COS_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240};
  localparam int unsigned COS_DIV_S [COS_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_AMPLITUDE  = 3'd0,
    REG_INV_WIDTH_SQ    = 3'd1,
    REG_CURVATURE_COEF  = 3'd2,
    REG_CARRIER_RATE    = 3'd3,
    REG_ENVELOPE_RATE   = 3'd4,
    REG_PULSE_DURATION  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [31:0]           sim_time;
    logic                         last_particle;
  } hla_in_t;

  typedef struct packed {
    logic signed [31:0] field_amplitude;
    logic               last_out;
  } hla_out_t;

  function automatic logic [30:0] clamp_unit(input logic signed [SUM_W-1:0] v);
    logic [30:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b000, Q30_ONE})) begin
      r = Q30_ONE[30:0];
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/hla_cos.sv @@
// Pipelined cosine of a phase in turns: quadrant reduction and Taylor series.
// Depends on hla_pkg; the pipeline advances only on cycles with en_i high.
`default_nettype none
module hla_cos #(
  parameter int PHASE_BITS = hla_pkg::PHASE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output logic signed [31:0]    cos_o
);
  import hla_pkg::*;

  localparam int REM_W = PHASE_BITS - 2;

  typedef struct packed {
    logic [31:0] th2;
    logic [1:0]  quad;
  } cx_t;

  logic [REM_W-1:0] rem;
  logic [29:0]      r30;
  logic [60:0]      th_prod;
  logic [61:0]      th2_prod;
  logic [30:0]      th0_q, th1_q;
  logic [1:0]       quad0_q;
  cx_t              cx1_q;

  logic [31:0]             xc_q  [COS_TERMS];
  logic [31:0]             xs_q  [COS_TERMS];
  logic signed [SUM_W-1:0] sca_q [COS_TERMS];
  logic signed [SUM_W-1:0] ssa_q [COS_TERMS];
  cx_t                     cxa_q [COS_TERMS];
  logic [31:0]             tcb_q [COS_TERMS];
  logic [31:0]             tsb_q [COS_TERMS];
  logic signed [SUM_W-1:0] scb_q [COS_TERMS];
  logic signed [SUM_W-1:0] ssb_q [COS_TERMS];
  cx_t                     cxb_q [COS_TERMS];

  logic [30:0] c_fin, s_fin;

  assign rem = phase_i[REM_W-1:0];

  if (PHASE_BITS >= 32) begin : g_down
    assign r30 = 30'(rem >> (PHASE_BITS - 32));
  end else begin : g_up
    assign r30 = 30'({rem, {(32 - PHASE_BITS){1'b0}}});
  end

  assign th_prod  = 61'(r30) * 61'(HALFPI_Q30);
  assign th2_prod = 62'(th0_q) * 62'(th0_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      th0_q      <= th_prod[60:30];
      quad0_q    <= phase_i[PHASE_BITS-1 -: 2];
      th1_q      <= th0_q;
      cx1_q.th2  <= th2_prod[61:30];
      cx1_q.quad <= quad0_q;
    end
  end

  for (genvar k = 0; k < COS_TERMS; k++) begin : g_term
    localparam int unsigned DC = COS_DIV_C[k];
    localparam int unsigned DS = COS_DIV_S[k];
    localparam int LC = $clog2(DC);
    localparam int LS = $clog2(DS);
    localparam int SHC = 32 + LC;
    localparam int SHS = 32 + LS;
    localparam logic [63:0] RCC = ((64'd1 << SHC) + 64'(DC) - 64'd1) / 64'(DC);
    localparam logic [63:0] RCS = ((64'd1 << SHS) + 64'(DS) - 64'd1) / 64'(DS);
    localparam bit SUB = (k % 2) == 0;

    logic [31:0]             tc_in, ts_in;
    logic signed [SUM_W-1:0] sc_in, ss_in;
    cx_t                     cx_in;
    logic [63:0]             pc, ps;
    logic [64:0]             dc, ds;
    logic [31:0]             qc, qs;

    if (k == 0) begin : g_first
      assign tc_in = Q30_ONE;
      assign ts_in = {1'b0, th1_q};
      assign sc_in = $signed({3'b000, Q30_ONE});
      assign ss_in = $signed({4'b0000, th1_q});
      assign cx_in = cx1_q;
    end else begin : g_next
      assign tc_in = tcb_q[k-1];
      assign ts_in = tsb_q[k-1];
      assign sc_in = scb_q[k-1];
      assign ss_in = ssb_q[k-1];
      assign cx_in = cxb_q[k-1];
    end

    assign pc = 64'(tc_in) * 64'(cx_in.th2);
    assign ps = 64'(ts_in) * 64'(cx_in.th2);
    assign dc = 65'(xc_q[k]) * 65'(RCC[32:0]);
    assign ds = 65'(xs_q[k]) * 65'(RCS[32:0]);
    assign qc = 32'(dc >> SHC);
    assign qs = 32'(ds >> SHS);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xc_q[k]  <= pc[61:30];
        xs_q[k]  <= ps[61:30];
        sca_q[k] <= sc_in;
        ssa_q[k] <= ss_in;
        cxa_q[k] <= cx_in;
        tcb_q[k] <= qc;
        tsb_q[k] <= qs;
        scb_q[k] <= SUB ? sca_q[k] - $signed({3'b000, qc}) : sca_q[k] + $signed({3'b000, qc});
        ssb_q[k] <= SUB ? ssa_q[k] - $signed({3'b000, qs}) : ssa_q[k] + $signed({3'b000, qs});
        cxb_q[k] <= cxa_q[k];
      end
    end
  end

  assign c_fin = clamp_unit(scb_q[COS_TERMS-1]);
  assign s_fin = clamp_unit(ssb_q[COS_TERMS-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (cxb_q[COS_TERMS-1].quad)
        2'd0:    cos_o <= $signed({1'b0, c_fin});
        2'd1:    cos_o <= -$signed({1'b0, s_fin});
        2'd2:    cos_o <= -$signed({1'b0, c_fin});
        default: cos_o <= $signed({1'b0, s_fin});
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/harris_laser_amplitude.sv @@
// Throughput: one request per cycle; the pipeline stalls as a whole only while
// the output register and its skid entry are both full.
// Reset clears all valid bits, the skid entry and the configuration registers.
// Top level of the Harris-envelope Gaussian-beam laser amplitude pipeline.
// Depends on hla_pkg, hla_cos and harris_laser_amplitude_macros.svh.
`default_nettype none
`include "harris_laser_amplitude_macros.svh"
module harris_laser_amplitude #(
  parameter int PHASE_BITS = hla_pkg::PHASE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [hla_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hla_pkg::hla_in_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hla_pkg::hla_out_t              out_req_o
);
  import hla_pkg::*;

  localparam int CSHIFT = (COORD_BITS > 32) ? COORD_BITS - 32 : 0;
  localparam int MAG_W  = (COORD_BITS > 32) ? COORD_BITS : 32;
  localparam int ENV_ST = 2 + COS_LAT + 1;
  localparam int OSC_ST = 5 + COS_LAT;
  localparam int G_ST   = 7 + 2 * EXP_TERMS + 1;
  localparam int M2_ST  = G_ST + 2;
  localparam int NST    = G_ST + 4;
  localparam logic signed [36:0] ENV_BASE = 37'sd10 <<< 30;
  localparam logic signed [36:0] ENV_MAX  = 37'sd1 <<< 35;

  typedef struct packed {
    logic [29:0] u;
    logic [4:0]  ip;
    logic        zero;
  } gx_t;

  function automatic logic [31:0] coord_mag(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS-1:0] m;
    logic [MAG_W-1:0]      e;
    m = v[COORD_BITS-1] ? (~v + 1'b1) : v;
    e = MAG_W'(m) >> CSHIFT;
    return e[31:0];
  endfunction

  // Configuration registers.
  logic [31:0]        peak_q, inv_q, car_rate_q, env_rate_q;
  logic signed [31:0] curv_q;
  logic [30:0]        dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q     <= '0;
      inv_q      <= '0;
      curv_q     <= '0;
      car_rate_q <= '0;
      env_rate_q <= '0;
      dur_q      <= '0;
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        REG_PEAK_AMPLITUDE: peak_q     <= cfg_data_i;
        REG_INV_WIDTH_SQ:   inv_q      <= cfg_data_i;
        REG_CURVATURE_COEF: curv_q     <= $signed(cfg_data_i);
        REG_CARRIER_RATE:   car_rate_q <= cfg_data_i;
        REG_ENVELOPE_RATE:  env_rate_q <= cfg_data_i;
        REG_PULSE_DURATION: dur_q      <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Flow control: the whole pipeline advances unless the skid entry is occupied.
  logic     en;
  logic     v_q [1:NST];
  logic     out_v_q, skid_v_q;
  hla_out_t out_q, skid_q, amp_res;
  logic     pipe_out_v;

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign pipe_out_v = v_q[NST] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= NST; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en) begin
      v_q[1] <= in_valid_i;
      for (int s = 2; s <= NST; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q  <= skid_v_q || pipe_out_v;
      skid_v_q <= 1'b0;
    end else if (pipe_out_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : amp_res;
    end else if (pipe_out_v) begin
      skid_q <= amp_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

  // Front stages: magnitudes, phases, r squared, Gaussian exponent.
  logic signed [64:0]    pe_prod, pc_prod;
  logic [31:0]           ax1_q, ay1_q;
  logic [PHASE_BITS-1:0] pe1_q;
  logic [PHASE_BITS-1:0] pc_q [1:4];
  logic                  tval_q [1:ENV_ST-1];
  logic                  last_q [1:NST-1];
  logic [63:0]           sqx2_q, sqy2_q, r2_3_q;
  logic [PHASE_BITS-1:0] penv2_q [3];
  logic [PHASE_BITS-1:0] p2;
  logic signed [64:0]    curv_hi4_q, curv_lo4_q, cq;
  logic [63:0]           phi4_q, plo4_q;
  logic [48:0]           e_full;
  logic [PHASE_BITS-1:0] ph5_q;
  logic [21:0]           e5_q;
  logic                  gz5_q, gz6_q;
  logic [52:0]           z6_q;
  logic [59:0]           u_prod;
  gx_t                   gx7_q;

  assign pe_prod = $signed({1'b0, env_rate_q}) * in_req_i.sim_time;
  assign pc_prod = $signed({1'b0, car_rate_q}) * in_req_i.sim_time;
  assign p2      = {pe1_q[PHASE_BITS-2:0], 1'b0};
  assign cq      = curv_hi4_q + (curv_lo4_q >>> 32);
  assign e_full  = {27'd0, phi4_q[5:0], 16'd0} + {1'b0, plo4_q[63:16]};
  assign u_prod  = 60'(z6_q[45:16]) * 60'(LN2_Q30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q     <= coord_mag(in_req_i.pos_x);
      ay1_q     <= coord_mag(in_req_i.pos_y);
      pe1_q     <= pe_prod[PHASE_BITS-1:0];
      pc_q[1]   <= pc_prod[PHASE_BITS-1:0];
      tval_q[1] <= in_req_i.sim_time < $signed({1'b0, dur_q});
      last_q[1] <= in_req_i.last_particle;
      for (int s = 2; s <= 4; s++) begin
        pc_q[s] <= pc_q[s-1];
      end
      for (int s = 2; s <= ENV_ST - 1; s++) begin
        tval_q[s] <= tval_q[s-1];
      end
      for (int s = 2; s <= NST - 1; s++) begin
        last_q[s] <= last_q[s-1];
      end

      sqx2_q     <= 64'(ax1_q) * 64'(ax1_q);
      sqy2_q     <= 64'(ay1_q) * 64'(ay1_q);
      penv2_q[0] <= pe1_q;
      penv2_q[1] <= p2;
      penv2_q[2] <= pe1_q + p2;

      r2_3_q <= sqx2_q + sqy2_q;

      curv_hi4_q <= curv_q * $signed({1'b0, r2_3_q[63:32]});
      curv_lo4_q <= curv_q * $signed({1'b0, r2_3_q[31:0]});
      phi4_q     <= 64'(r2_3_q[63:32]) * 64'(inv_q);
      plo4_q     <= 64'(r2_3_q[31:0]) * 64'(inv_q);

      ph5_q <= pc_q[4] - cq[PHASE_BITS-1:0];
      e5_q  <= e_full[21:0];
      gz5_q <= (|phi4_q[63:6]) || (|e_full[48:22]);

      z6_q  <= 53'(e5_q) * 53'(LOG2E_Q30);
      gz6_q <= gz5_q;

      gx7_q.u    <= u_prod[59:30];
      gx7_q.ip   <= z6_q[50:46];
      gx7_q.zero <= gz6_q || (z6_q[52:46] >= 7'd31);
    end
  end

  // Gaussian: Taylor series of exp on the fractional part.
  logic [31:0]             xe_q  [EXP_TERMS];
  logic signed [SUM_W-1:0] sea_q [EXP_TERMS];
  gx_t                     gea_q [EXP_TERMS];
  logic [31:0]             teb_q [EXP_TERMS];
  logic signed [SUM_W-1:0] seb_q [EXP_TERMS];
  gx_t                     geb_q [EXP_TERMS];
  logic [30:0]             g_q;

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
    localparam int unsigned D = j + 1;
    localparam int L = $clog2(D);
    localparam int SH = 32 + L;
    localparam logic [63:0] RC = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);
    localparam bit SUB = (j % 2) == 0;

    logic [31:0]             t_in;
    logic signed [SUM_W-1:0] s_in;
    gx_t                     g_in;
    logic [61:0]             xp;
    logic [64:0]             dp;
    logic [31:0]             q;

    if (j == 0) begin : g_first
      assign t_in = Q30_ONE;
      assign s_in = $signed({3'b000, Q30_ONE});
      assign g_in = gx7_q;
    end else begin : g_next
      assign t_in = teb_q[j-1];
      assign s_in = seb_q[j-1];
      assign g_in = geb_q[j-1];
    end

    assign xp = 62'(t_in) * 62'(g_in.u);
    assign dp = 65'(xe_q[j]) * 65'(RC[32:0]);
    assign q  = 32'(dp >> SH);

    always_ff @(posedge clk_i) begin
      if (en) begin
        xe_q[j]  <= xp[61:30];
        sea_q[j] <= s_in;
        gea_q[j] <= g_in;
        teb_q[j] <= q;
        seb_q[j] <= SUB ? sea_q[j] - $signed({3'b000, q}) : sea_q[j] + $signed({3'b000, q});
        geb_q[j] <= gea_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q <= geb_q[EXP_TERMS-1].zero ? '0
           : clamp_unit(seb_q[EXP_TERMS-1]) >> geb_q[EXP_TERMS-1].ip;
    end
  end

  // Envelope and carrier cosines.
  logic signed [31:0] cenv [3];
  logic signed [31:0] osc;

  for (genvar h = 0; h < 3; h++) begin : g_env_cos
    hla_cos #(.PHASE_BITS(PHASE_BITS)) u_env_cos (
      .clk_i   (clk_i),
      .en_i    (en),
      .phase_i (penv2_q[h]),
      .cos_o   (cenv[h])
    );
  end

  hla_cos #(.PHASE_BITS(PHASE_BITS)) u_osc_cos (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (ph5_q),
    .cos_o   (osc)
  );

  logic signed [36:0] esum;
  logic [30:0]        env_d;
  logic [30:0]        env_q [ENV_ST:G_ST];
  logic signed [31:0] osc_q [OSC_ST+1:M2_ST];

  always_comb begin
    esum = ENV_BASE - 37'(cenv[0]) * 37'sd15 + 37'(cenv[1]) * 37'sd6 - 37'(cenv[2]);
    if (!tval_q[ENV_ST-1] || esum < 0) begin
      env_d = '0;
    end else if (esum > ENV_MAX) begin
      env_d = ENV_MAX[35:5];
    end else begin
      env_d = esum[35:5];
    end
  end

  // Products, sign and saturation.
  logic [61:0] m1_prod;
  logic [62:0] m2_prod;
  logic [63:0] m3_prod;
  logic [30:0] m1_q, osc_abs;
  logic [32:0] m2_q;
  logic [33:0] m3_q;
  logic        neg_q;
  hla_out_t    amp_q;

  assign osc_abs = osc_q[M2_ST][31] ? 31'(-osc_q[M2_ST]) : 31'(osc_q[M2_ST]);
  assign m1_prod = 62'(env_q[G_ST]) * 62'(g_q);
  assign m2_prod = 63'(m1_q) * 63'(peak_q);
  assign m3_prod = 64'(m2_q) * 64'(osc_abs);

  always_ff @(posedge clk_i) begin
    if (en) begin
      env_q[ENV_ST] <= env_d;
      for (int s = ENV_ST + 1; s <= G_ST; s++) begin
        env_q[s] <= env_q[s-1];
      end
      osc_q[OSC_ST+1] <= osc;
      for (int s = OSC_ST + 2; s <= M2_ST; s++) begin
        osc_q[s] <= osc_q[s-1];
      end
      m1_q  <= m1_prod[60:30];
      m2_q  <= m2_prod[62:30];
      m3_q  <= m3_prod[63:30];
      neg_q <= osc_q[M2_ST][31];
      if (neg_q) begin
        amp_q.field_amplitude <= (m3_q > 34'h0_8000_0000) ? 32'sh8000_0000
                                 : -$signed(m3_q[31:0]);
      end else begin
        amp_q.field_amplitude <= (m3_q > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                 : $signed(m3_q[31:0]);
      end
      amp_q.last_out <= last_q[NST-1];
    end
  end

  assign amp_res = amp_q;

  `HLA_ASSERT_IMP(a_skid_implies_out, skid_v_q, out_v_q, "skid entry held without output entry")
  `HLA_ASSERT_NXT(a_stall_fills_skid, out_v_q && !out_ready_i && v_q[NST] && !skid_v_q,
                  skid_v_q, "stalled result not captured in skid entry")
  `HLA_ASSERT_NXT(a_pipe_holds, v_q[NST] && !en, v_q[NST], "result lost during stall")
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the Harris-envelope Gaussian-beam laser amplitude pipeline.
// It predicts every result in an internal scoreboard and drives random idling on both sides.
// Depends on hla_pkg and the harris_laser_amplitude RTL.
`timescale 1ns / 100ps

class amplitude_scoreboard;
  typedef longint unsigned u64_t;

  localparam longint unsigned ONE = 64'd1 << 30;
  localparam longint unsigned PMASK = 64'hFFFF_FFFF;
  localparam longint unsigned HALFPI = 64'd1686629713;
  localparam longint unsigned LN2 = 64'd744261118;
  localparam longint unsigned LOG2E = 64'd1549082005;

  hla_pkg::hla_out_t expected_q[$];
  int errors;
  longint unsigned peak, inv_width_sq, carrier_rate, envelope_rate, duration;
  longint curv_coef;

  function new();
    errors = 0;
    peak = 0;
    inv_width_sq = 0;
    curv_coef = 0;
    carrier_rate = 0;
    envelope_rate = 0;
    duration = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      hla_pkg::REG_PEAK_AMPLITUDE: peak = d;
      hla_pkg::REG_INV_WIDTH_SQ: inv_width_sq = d;
      hla_pkg::REG_CURVATURE_COEF: curv_coef = longint'($signed(d));
      hla_pkg::REG_CARRIER_RATE: carrier_rate = d;
      hla_pkg::REG_ENVELOPE_RATE: envelope_rate = d;
      hla_pkg::REG_PULSE_DURATION: duration = d[30:0];
      default: ;
    endcase
  endfunction

  function longint clamp_one(longint v);
    if (v < 0) return 0;
    if (v > longint'(ONE)) return longint'(ONE);
    return v;
  endfunction

  function longint cos_q30(longint unsigned p);
    longint unsigned quad, th, th2, term;
    longint c, s;
    p = p & PMASK;
    quad = (p >> 30) & 3;
    th = ((p & 64'h3FFF_FFFF) * HALFPI) >> 30;
    th2 = (th * th) >> 30;
    c = longint'(ONE);
    term = ONE;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * th2) >> 30) / u64_t'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) c = c - $signed(term);
      else c = c + $signed(term);
    end
    s = $signed(th);
    term = th;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * th2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - $signed(term);
      else s = s + $signed(term);
    end
    c = clamp_one(c);
    s = clamp_one(s);
    case (quad)
      0: return c;
      1: return -s;
      2: return -c;
      default: return s;
    endcase
  endfunction

  function longint unsigned gaussian_q30(longint unsigned r2);
    longint unsigned phi, plo, e, z, ip, u, term;
    longint sum;
    phi = (r2 >> 32) * inv_width_sq;
    plo = (r2 & PMASK) * inv_width_sq;
    if (phi >= 64) return 0;
    e = (phi << 16) + (plo >> 16);
    if (e >= (64'd64 << 16)) return 0;
    z = e * LOG2E;
    ip = z >> 46;
    u = (((z >> 16) & (ONE - 1)) * LN2) >> 30;
    if (ip >= 31) return 0;
    sum = longint'(ONE);
    term = ONE;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * u) >> 30) / u64_t'(k);
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    return u64_t'(clamp_one(sum)) >> ip;
  endfunction

  function longint unsigned curvature_turns(longint unsigned r2);
    longint unsigned m, lowprod, q;
    m = curv_coef < 0 ? u64_t'(-curv_coef) : u64_t'(curv_coef);
    lowprod = m * (r2 & PMASK);
    q = m * (r2 >> 32) + (lowprod >> 32);
    if (curv_coef < 0) q = 64'd0 - q - (((lowprod & PMASK) != 0) ? 64'd1 : 64'd0);
    return q & PMASK;
  endfunction

  function hla_pkg::hla_out_t predict_amplitude(hla_pkg::hla_in_t r);
    hla_pkg::hla_out_t res;
    longint unsigned ax, ay, r2, tu, pe, env, g, ph, m1, m2, m3;
    longint t, sum, osc, amp;
    ax = r.pos_x < 0 ? u64_t'(-longint'(r.pos_x)) : u64_t'(longint'(r.pos_x));
    ay = r.pos_y < 0 ? u64_t'(-longint'(r.pos_y)) : u64_t'(longint'(r.pos_y));
    r2 = ax * ax + ay * ay;
    t = longint'(r.sim_time);
    tu = u64_t'(t);
    env = 0;
    if (t < longint'(duration)) begin
      pe = (envelope_rate * tu) & PMASK;
      sum = 10 * longint'(ONE) - 15 * cos_q30(pe) + 6 * cos_q30(pe * 2) - cos_q30(pe * 3);
      if (sum < 0) sum = 0;
      if (sum > 32 * longint'(ONE)) sum = 32 * longint'(ONE);
      env = u64_t'(sum) >> 5;
    end
    g = gaussian_q30(r2);
    ph = (carrier_rate * tu - curvature_turns(r2)) & PMASK;
    osc = cos_q30(ph);
    m1 = (env * g) >> 30;
    m2 = (m1 * peak) >> 30;
    m3 = (m2 * u64_t'(osc < 0 ? -osc : osc)) >> 30;
    if (osc < 0) amp = m3 > 64'h8000_0000 ? -longint'(64'h8000_0000) : -longint'(m3);
    else amp = m3 > 64'h7FFF_FFFF ? longint'(64'h7FFF_FFFF) : longint'(m3);
    res.field_amplitude = amp[31:0];
    res.last_out = r.last_particle;
    return res;
  endfunction

  function void note_request(hla_pkg::hla_in_t r);
    expected_q.push_back(predict_amplitude(r));
  endfunction

  function void check_result(hla_pkg::hla_out_t got);
    hla_pkg::hla_out_t exp_res;
    if (expected_q.size() == 0) begin
      $error("field_amplitude: no result expected, got %0d", got.field_amplitude);
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    if (got.field_amplitude !== exp_res.field_amplitude) begin
      $error("field_amplitude: expected %0d, got %0d",
             exp_res.field_amplitude, got.field_amplitude);
      errors++;
    end
    if (got.last_out !== exp_res.last_out) begin
      $error("last_out: expected %0d, got %0d", exp_res.last_out, got.last_out);
      errors++;
    end
  endfunction
endclass

module tb;
  import hla_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  hla_in_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  hla_out_t out_req_o;

  amplitude_scoreboard sb = new();
  bit idle_en = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int unsigned cur_dur = 0;

  harris_laser_amplitude uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_wr_en_i(cfg_wr_en_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_req_o(out_req_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (!idle_en) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_req_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(hla_in_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [31:0] x, logic [31:0] y, logic [31:0] t, logic last);
    hla_in_t r;
    r.pos_x = x;
    r.pos_y = y;
    r.sim_time = t;
    r.last_particle = last;
    send_request(r);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_wr_en_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    sb.set_reg(idx, d);
    if (idx == REG_PULSE_DURATION) cur_dur = d[30:0];
    @(negedge clk_i);
  endtask

  task automatic load_config(logic [31:0] pk, logic [31:0] inv, logic [31:0] coef,
                             logic [31:0] car, logic [31:0] envr, logic [31:0] dur);
    write_reg(REG_PEAK_AMPLITUDE, pk);
    write_reg(REG_INV_WIDTH_SQ, inv);
    write_reg(REG_CURVATURE_COEF, coef);
    write_reg(REG_CARRIER_RATE, car);
    write_reg(REG_ENVELOPE_RATE, envr);
    write_reg(REG_PULSE_DURATION, dur);
    cfg_wr_en_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    if ($urandom_range(0, 3) == 0) return $urandom;
    v = $urandom >> $urandom_range(1, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return -($urandom >> $urandom_range(0, 31));
      2: return cur_dur + $urandom_range(0, 3);
      default: return cur_dur == 0 ? 32'd0 : $urandom_range(0, cur_dur - 1);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] dur, envr;
    dur = ($urandom >> 1) >> $urandom_range(0, 28);
    envr = (dur > 1 && $urandom_range(0, 2) != 0) ? 32'(64'h1_0000_0000 / dur) : $urandom;
    load_config($urandom >> $urandom_range(0, 8), $urandom >> $urandom_range(0, 31),
                $urandom >> $urandom_range(0, 31) ^ {1'($urandom_range(0, 1)), 31'd0},
                $urandom >> $urandom_range(0, 24), envr, dur);
    repeat (n) send_fields(rand_coord(), rand_coord(), rand_time(), 1'($urandom_range(0, 1)));
    drain_pipeline();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_fields(32'd0, 32'd0, 32'd0, 1'b1);
    send_fields(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0);
    drain_pipeline();

    // Full peak on axis: the envelope top and a half-turn carrier saturate negative.
    load_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_fields(32'd0, 32'd0, 32'd1, 1'b0);
    send_fields(32'd0, 32'd0, 32'd2, 1'b1);
    send_fields(32'd0, 32'd0, 32'd3, 1'b0);
    send_fields(32'd0, 32'd0, 32'h7FFF_FFFE, 1'b0);
    send_fields(32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1);
    send_fields(32'd0, 32'd0, 32'h8000_0001, 1'b0);
    drain_pipeline();
    write_reg(REG_CARRIER_RATE, 32'd0);
    write_reg(REG_UNUSED_A, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED_B, 32'h1234_5678);
    cfg_wr_en_i <= 1'b0;
    @(negedge clk_i);
    send_fields(32'd0, 32'd0, 32'd1, 1'b1);
    send_fields(32'd3, 32'hFFFF_FFFD, 32'd1, 1'b0);
    drain_pipeline();

    load_config(32'h4000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'd0);
    send_fields(32'd100, 32'hFFFF_FF00, 32'hFFFF_FFF0, 1'b0);
    send_fields(32'd0, 32'd0, 32'h8000_0000, 1'b1);
    send_fields(32'd0, 32'd0, 32'd0, 1'b0);
    drain_pipeline();

    load_config(32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'h0100_0000, 32'h0001_0000, 32'd65536);
    send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'd32768, 1'b0);
    send_fields(32'h0001_0000, 32'hFFFF_0000, 32'd32768, 1'b1);
    send_fields(32'd0, 32'd0, 32'd65535, 1'b0);
    send_fields(32'd0, 32'd0, 32'd65536, 1'b1);
    drain_pipeline();

    repeat (8) random_phase(100);
    idle_en = 1'b0;
    random_phase(90);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/hla_pkg.sv
rtl/hla_cos.sv
rtl/harris_laser_amplitude.sv
verif/tb.sv
